@@ hw/rtl/r2n_pkg.sv @@
// Shared constants, types and helper functions for the RGB to NV12 converter.
// No dependencies; every other file of the block refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package r2n_pkg;

    // Frame size limits and the widths that follow from them.
    localparam int unsigned MAX_WIDTH  = 4096;
    localparam int unsigned MAX_HEIGHT = 4096;
    localparam int unsigned COL_W      = $clog2(MAX_WIDTH);
    localparam int unsigned ROW_W      = $clog2(MAX_HEIGHT);
    localparam int unsigned WID_W      = $clog2(MAX_WIDTH + 1);
    localparam int unsigned HGT_W      = $clog2(MAX_HEIGHT + 1);
    localparam int unsigned LINE_DEPTH = MAX_WIDTH / 2;
    localparam int unsigned LINE_AW    = COL_W - 1;

    // Configuration port.
    localparam int unsigned CFG_W     = 13;
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;
    localparam int unsigned RESET_WIDTH  = 640;
    localparam int unsigned RESET_HEIGHT = 480;

    // Payload widths.
    localparam int unsigned PIX_W  = 8;
    localparam int unsigned OFF_W  = 24;
    localparam int unsigned PAIR_W = PIX_W + 1;

    // Plane codes.
    localparam logic PLANE_LUMA   = 1'b0;
    localparam logic PLANE_CHROMA = 1'b1;

    // Color conversion arithmetic, all unsigned; negative terms are subtracted.
    localparam int unsigned SUM_W = 17;
    localparam logic [SUM_W-1:0] CY_R        = 17'd66;
    localparam logic [SUM_W-1:0] CY_G        = 17'd129;
    localparam logic [SUM_W-1:0] CY_B        = 17'd25;
    localparam logic [SUM_W-1:0] CU_R_NEG    = 17'd38;
    localparam logic [SUM_W-1:0] CU_G_NEG    = 17'd74;
    localparam logic [SUM_W-1:0] CU_B        = 17'd112;
    localparam logic [SUM_W-1:0] CV_R        = 17'd112;
    localparam logic [SUM_W-1:0] CV_G_NEG    = 17'd94;
    localparam logic [SUM_W-1:0] CV_B_NEG    = 17'd18;
    localparam logic [SUM_W-1:0] ROUND_BIAS  = 17'd128;
    localparam logic [SUM_W-1:0] CHROMA_BIAS = 17'd32768;
    localparam logic [PIX_W-1:0] LUMA_FLOOR  = 8'd16;

    // Result queue.
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic             plane;
        logic [OFF_W-1:0] offset;
        logic [PIX_W-1:0] first_value;
        logic [PIX_W-1:0] second_value;
        logic             last_of_run;
        logic             frame_end;
    } t_result;

    // Effective frame size: low bit cleared, raised to 2, capped at the even limit.
    function automatic int unsigned eff_size(input logic [CFG_W-1:0] raw,
                                             input int unsigned maxv);
        int unsigned s;
        s = int'({raw[CFG_W-1:1], 1'b0});
        if (s < 2) begin
            s = 2;
        end
        if (s > maxv) begin
            s = maxv & ~32'd1;
        end
        return s;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/r2n_color.sv @@
// BT.601 limited-range color conversion of one RGB pixel to Y, U and V bytes.
// Depends on r2n_pkg for the coefficients and widths.
`timescale 1ns / 1ps
`default_nettype none

module r2n_color (
    input  wire logic [r2n_pkg::PIX_W-1:0] i_red,
    input  wire logic [r2n_pkg::PIX_W-1:0] i_green,
    input  wire logic [r2n_pkg::PIX_W-1:0] i_blue,
    output logic      [r2n_pkg::PIX_W-1:0] o_y,
    output logic      [r2n_pkg::PIX_W-1:0] o_u,
    output logic      [r2n_pkg::PIX_W-1:0] o_v
);

    logic [r2n_pkg::SUM_W-1:0] red_x;
    logic [r2n_pkg::SUM_W-1:0] green_x;
    logic [r2n_pkg::SUM_W-1:0] blue_x;
    logic [r2n_pkg::SUM_W-1:0] y_sum;
    logic [r2n_pkg::SUM_W-1:0] u_sum;
    logic [r2n_pkg::SUM_W-1:0] v_sum;

    assign red_x   = r2n_pkg::SUM_W'(i_red);
    assign green_x = r2n_pkg::SUM_W'(i_green);
    assign blue_x  = r2n_pkg::SUM_W'(i_blue);

    // The chroma sums carry a bias that keeps them positive, so the byte is a plain
    // bit slice and matches a floor shift of the signed sum.
    assign y_sum = r2n_pkg::CY_R * red_x + r2n_pkg::CY_G * green_x
                 + r2n_pkg::CY_B * blue_x + r2n_pkg::ROUND_BIAS;
    assign u_sum = r2n_pkg::CU_B * blue_x + r2n_pkg::ROUND_BIAS + r2n_pkg::CHROMA_BIAS
                 - r2n_pkg::CU_R_NEG * red_x - r2n_pkg::CU_G_NEG * green_x;
    assign v_sum = r2n_pkg::CV_R * red_x + r2n_pkg::ROUND_BIAS + r2n_pkg::CHROMA_BIAS
                 - r2n_pkg::CV_G_NEG * green_x - r2n_pkg::CV_B_NEG * blue_x;

    assign o_y = y_sum[15:8] + r2n_pkg::LUMA_FLOOR;
    assign o_u = u_sum[15:8];
    assign o_v = v_sum[15:8];

endmodule

`default_nettype wire

@@ hw/rtl/r2n_out_fifo.sv @@
// Small result queue that takes one or two results per cycle and hands out one.
// Depends on r2n_pkg for the result type and the queue depth.
`timescale 1ns / 1ps
`default_nettype none

module r2n_out_fifo (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push0,
    input  wire logic             i_push1,
    input  wire r2n_pkg::t_result i_data0,
    input  wire r2n_pkg::t_result i_data1,
    output logic                  o_room2,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output r2n_pkg::t_result      o_data
);

    r2n_pkg::t_result                  r_mem [r2n_pkg::FIFO_DEPTH];
    logic [r2n_pkg::FIFO_AW-1:0]       r_wr_ptr;
    logic [r2n_pkg::FIFO_AW-1:0]       r_rd_ptr;
    logic [r2n_pkg::FIFO_CW-1:0]       r_count;
    logic [r2n_pkg::FIFO_AW-1:0]       n_wr_ptr;
    logic [r2n_pkg::FIFO_AW-1:0]       n_rd_ptr;
    logic [r2n_pkg::FIFO_CW-1:0]       n_count;
    logic [r2n_pkg::FIFO_AW-1:0]       wr_ptr_next;
    logic [r2n_pkg::FIFO_CW-1:0]       push_cnt;
    logic                              pop;

    assign o_valid     = (r_count != '0);
    assign o_data      = r_mem[r_rd_ptr];
    assign o_room2     = (r_count <= r2n_pkg::FIFO_CW'(r2n_pkg::FIFO_DEPTH - 2));
    assign pop         = o_valid && i_ready;
    assign wr_ptr_next = r_wr_ptr + r2n_pkg::FIFO_AW'(1);
    assign push_cnt    = r2n_pkg::FIFO_CW'(i_push0) + r2n_pkg::FIFO_CW'(i_push1);

    always_comb begin
        n_wr_ptr = r_wr_ptr + r2n_pkg::FIFO_AW'(push_cnt);
        n_rd_ptr = pop ? r_rd_ptr + r2n_pkg::FIFO_AW'(1) : r_rd_ptr;
        n_count  = r_count + push_cnt - r2n_pkg::FIFO_CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push0) begin
            r_mem[r_wr_ptr] <= i_data0;
        end
        if (i_push1) begin
            r_mem[wr_ptr_next] <= i_data1;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/rgb_to_nv12_converter.sv @@
// RGB to NV12 converter, BT.601 limited range, results tagged with plane and offset.
// A pixel passes through the stage A and stage B registers and then the result queue.
// Throughput: one pixel per cycle while the output is taken every cycle; a pixel at
// an odd column of an odd row gives two results, and the single output port sets
// the rate there. Reset is synchronous and active low; it clears positions, pipeline
// valid bits and the result queue, and loads sizes 640 by 480. No clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module rgb_to_nv12_converter (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // Pixel input channel.
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire logic [r2n_pkg::PIX_W-1:0]       i_red,
    input  wire logic [r2n_pkg::PIX_W-1:0]       i_green,
    input  wire logic [r2n_pkg::PIX_W-1:0]       i_blue,
    // Result output channel.
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output logic                                 o_plane,
    output logic      [r2n_pkg::OFF_W-1:0]       o_offset,
    output logic      [r2n_pkg::PIX_W-1:0]       o_first_value,
    output logic      [r2n_pkg::PIX_W-1:0]       o_second_value,
    output logic                                 o_last_of_run,
    output logic                                 o_frame_end,
    // Configuration write port.
    input  wire logic                            i_cfg_we,
    input  wire logic [r2n_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [r2n_pkg::CFG_W-1:0]       i_cfg_data
);

    // Position information that travels with a pixel through the pipeline.
    typedef struct packed {
        logic                          odd_col;
        logic                          odd_row;
        logic [r2n_pkg::LINE_AW-1:0]   idx;
        logic [r2n_pkg::OFF_W-1:0]     luma_off;
        logic [r2n_pkg::OFF_W-1:0]     chroma_off;
        logic                          last_px;
    } t_tag;

    // Effective frame size, clamped when written.
    logic [r2n_pkg::WID_W-1:0]  r_width;
    logic [r2n_pkg::HGT_W-1:0]  r_height;

    // Raster position of the next accepted pixel and its running offsets.
    logic [r2n_pkg::COL_W-1:0]  r_col;
    logic [r2n_pkg::ROW_W-1:0]  r_row;
    logic [r2n_pkg::OFF_W-1:0]  r_luma_off;
    logic [r2n_pkg::OFF_W-1:0]  r_cbase;
    logic [r2n_pkg::COL_W-1:0]  n_col;
    logic [r2n_pkg::ROW_W-1:0]  n_row;
    logic [r2n_pkg::OFF_W-1:0]  n_luma_off;
    logic [r2n_pkg::OFF_W-1:0]  n_cbase;
    logic                       col_end;
    logic                       row_end;
    t_tag                       in_tag;

    // Stage A: the registered input pixel.
    logic                       r_a_valid;
    logic [r2n_pkg::PIX_W-1:0]  r_a_red;
    logic [r2n_pkg::PIX_W-1:0]  r_a_green;
    logic [r2n_pkg::PIX_W-1:0]  r_a_blue;
    t_tag                       r_a_tag;
    logic [r2n_pkg::PIX_W-1:0]  a_y;
    logic [r2n_pkg::PIX_W-1:0]  a_u;
    logic [r2n_pkg::PIX_W-1:0]  a_v;

    // Stage B: converted pixel plus the line store entry of its column pair.
    logic                       r_b_valid;
    t_tag                       r_b_tag;
    logic [r2n_pkg::PIX_W-1:0]  r_b_y;
    logic [r2n_pkg::PIX_W-1:0]  r_b_u;
    logic [r2n_pkg::PIX_W-1:0]  r_b_v;
    logic [2*r2n_pkg::PAIR_W-1:0] r_b_line;

    // U and V of the last even-column pixel.
    logic [r2n_pkg::PIX_W-1:0]  r_left_u;
    logic [r2n_pkg::PIX_W-1:0]  r_left_v;

    // Line store: U and V pair sums of each column pair of the last even row.
    logic [2*r2n_pkg::PAIR_W-1:0] r_line_mem [r2n_pkg::LINE_DEPTH];

    logic [r2n_pkg::PAIR_W-1:0]   pair_u;
    logic [r2n_pkg::PAIR_W-1:0]   pair_v;
    logic [r2n_pkg::PAIR_W:0]     quad_u;
    logic [r2n_pkg::PAIR_W:0]     quad_v;

    logic                       in_acc;
    logic                       a_adv;
    logic                       a_free;
    logic                       b_adv;
    logic                       b_free;
    logic                       b_chroma;
    logic                       b_line_wr;
    logic                       fifo_room2;
    r2n_pkg::t_result           res_luma;
    r2n_pkg::t_result           res_chroma;
    r2n_pkg::t_result           out_res;

    // Pipeline flow control. Stage B moves on only when the queue can take two
    // results, so a pair never has to be split.
    assign b_adv   = r_b_valid && fifo_room2;
    assign b_free  = !r_b_valid || fifo_room2;
    assign a_adv   = r_a_valid && b_free;
    assign a_free  = !r_a_valid || b_free;
    assign o_ready = a_free;
    assign in_acc  = i_valid && a_free;

    // Raster bookkeeping for the pixel at the input.
    always_comb begin
        col_end = (r2n_pkg::WID_W'(r_col) + r2n_pkg::WID_W'(1)) >= r_width;
        row_end = (r2n_pkg::HGT_W'(r_row) + r2n_pkg::HGT_W'(1)) >= r_height;

        in_tag.odd_col    = r_col[0];
        in_tag.odd_row    = r_row[0];
        in_tag.idx        = r_col[r2n_pkg::COL_W-1:1];
        in_tag.luma_off   = r_luma_off;
        in_tag.chroma_off = r_cbase + r2n_pkg::OFF_W'({r_col[r2n_pkg::COL_W-1:1], 1'b0});
        in_tag.last_px    = col_end && row_end;

        n_col      = r_col;
        n_row      = r_row;
        n_luma_off = r_luma_off;
        n_cbase    = r_cbase;
        if (in_acc) begin
            if (col_end) begin
                n_col = '0;
                if (row_end) begin
                    n_row      = '0;
                    n_luma_off = '0;
                    n_cbase    = '0;
                end else begin
                    n_row      = r_row + r2n_pkg::ROW_W'(1);
                    n_luma_off = r_luma_off + r2n_pkg::OFF_W'(1);
                    // Chroma rows advance once per pair of luma rows.
                    if (r_row[0]) begin
                        n_cbase = r_cbase + r2n_pkg::OFF_W'(r_width);
                    end
                end
            end else begin
                n_col      = r_col + r2n_pkg::COL_W'(1);
                n_luma_off = r_luma_off + r2n_pkg::OFF_W'(1);
            end
        end
    end

    // Size registers and position counters. Any size write restarts the frame.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width    <= r2n_pkg::WID_W'(r2n_pkg::RESET_WIDTH);
            r_height   <= r2n_pkg::HGT_W'(r2n_pkg::RESET_HEIGHT);
            r_col      <= '0;
            r_row      <= '0;
            r_luma_off <= '0;
            r_cbase    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                r2n_pkg::REG_FRAME_WIDTH: begin
                    r_width <= r2n_pkg::WID_W'(
                        r2n_pkg::eff_size(i_cfg_data, r2n_pkg::MAX_WIDTH));
                end
                r2n_pkg::REG_FRAME_HEIGHT: begin
                    r_height <= r2n_pkg::HGT_W'(
                        r2n_pkg::eff_size(i_cfg_data, r2n_pkg::MAX_HEIGHT));
                end
                default: begin
                end
            endcase
            r_col      <= '0;
            r_row      <= '0;
            r_luma_off <= '0;
            r_cbase    <= '0;
        end else begin
            r_col      <= n_col;
            r_row      <= n_row;
            r_luma_off <= n_luma_off;
            r_cbase    <= n_cbase;
        end
    end

    // Stage A register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (a_free) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a_red   <= i_red;
            r_a_green <= i_green;
            r_a_blue  <= i_blue;
            r_a_tag   <= in_tag;
        end
    end

    r2n_color u_color (
        .i_red   (r_a_red),
        .i_green (r_a_green),
        .i_blue  (r_a_blue),
        .o_y     (a_y),
        .o_u     (a_u),
        .o_v     (a_v)
    );

    // Stage B register. The line store is read as the pixel enters stage B.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (b_free) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_adv) begin
            r_b_tag <= r_a_tag;
            r_b_y   <= a_y;
            r_b_u   <= a_u;
            r_b_v   <= a_v;
        end
    end

    // The pair sums of an even row are written before the odd row reads them, since
    // all but one pixel of a row lie between the write and the read.
    always_ff @(posedge i_clk) begin
        if (a_adv) begin
            r_b_line <= r_line_mem[r_a_tag.idx];
        end
        if (b_line_wr) begin
            r_line_mem[r_b_tag.idx] <= {pair_v, pair_u};
        end
    end

    // Chroma of the 2x2 block: left pixel plus this pixel, plus the row above.
    always_comb begin
        pair_u    = r2n_pkg::PAIR_W'(r_left_u) + r2n_pkg::PAIR_W'(r_b_u);
        pair_v    = r2n_pkg::PAIR_W'(r_left_v) + r2n_pkg::PAIR_W'(r_b_v);
        quad_u    = (r2n_pkg::PAIR_W+1)'(r_b_line[r2n_pkg::PAIR_W-1:0])
                  + (r2n_pkg::PAIR_W+1)'(pair_u);
        quad_v    = (r2n_pkg::PAIR_W+1)'(r_b_line[2*r2n_pkg::PAIR_W-1:r2n_pkg::PAIR_W])
                  + (r2n_pkg::PAIR_W+1)'(pair_v);
        b_chroma  = r_b_tag.odd_col && r_b_tag.odd_row;
        b_line_wr = b_adv && r_b_tag.odd_col && !r_b_tag.odd_row;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_u <= '0;
            r_left_v <= '0;
        end else if (b_adv && !r_b_tag.odd_col) begin
            r_left_u <= r_b_u;
            r_left_v <= r_b_v;
        end
    end

    // Results of the pixel in stage B.
    always_comb begin
        res_luma.plane        = r2n_pkg::PLANE_LUMA;
        res_luma.offset       = r_b_tag.luma_off;
        res_luma.first_value  = r_b_y;
        res_luma.second_value = '0;
        res_luma.last_of_run  = !b_chroma;
        res_luma.frame_end    = !b_chroma && r_b_tag.last_px;

        res_chroma.plane        = r2n_pkg::PLANE_CHROMA;
        res_chroma.offset       = r_b_tag.chroma_off;
        res_chroma.first_value  = quad_u[r2n_pkg::PAIR_W:2];
        res_chroma.second_value = quad_v[r2n_pkg::PAIR_W:2];
        res_chroma.last_of_run  = 1'b1;
        res_chroma.frame_end    = r_b_tag.last_px;
    end

    r2n_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push0 (b_adv),
        .i_push1 (b_adv && b_chroma),
        .i_data0 (res_luma),
        .i_data1 (res_chroma),
        .o_room2 (fifo_room2),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (out_res)
    );

    assign o_plane        = out_res.plane;
    assign o_offset       = out_res.offset;
    assign o_first_value  = out_res.first_value;
    assign o_second_value = out_res.second_value;
    assign o_last_of_run  = out_res.last_of_run;
    assign o_frame_end    = out_res.frame_end;

endmodule

`default_nettype wire

@@ bench/rgb_to_nv12_converter_tb.sv @@
// Self-checking testbench for the RGB to NV12 converter.
// Depends on r2n_pkg and rgb_to_nv12_converter; it compares every plane write with its own
// per-pixel prediction of luma, 2x2 chroma averages, offsets and end-of-frame flags.
`timescale 1ns / 1ps

module rgb_to_nv12_converter_tb;

    // Watchdog, receiver hold-off and end-of-run settling, all in clock cycles.
    localparam int CYCLE_LIMIT  = 500000;
    localparam int HOLD_CYCLES  = 64;
    localparam int DRAIN_CYCLES = 20;

    // Kinds of row in the opening table: a pixel to send or a size register to write.
    typedef enum logic {ROW_PIXEL, ROW_WRITE} t_row_kind;

    // One row of the opening table. A pixel row may carry a luma byte and a luma offset that
    // are obvious from the conversion formula; those replace the predicted ones.
    typedef struct {
        t_row_kind                     kind;
        logic [r2n_pkg::PIX_W-1:0]     red;
        logic [r2n_pkg::PIX_W-1:0]     green;
        logic [r2n_pkg::PIX_W-1:0]     blue;
        bit                            typed;
        logic [r2n_pkg::PIX_W-1:0]     typed_luma;
        logic [r2n_pkg::OFF_W-1:0]     typed_offset;
        logic [r2n_pkg::CFG_IDX_W-1:0] reg_index;
        logic [r2n_pkg::CFG_W-1:0]     reg_data;
    } t_stim_row;

    // Block ports. Every input starts at a known value.
    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_valid = 1'b0;
    logic                          o_ready;
    logic [r2n_pkg::PIX_W-1:0]     i_red = '0;
    logic [r2n_pkg::PIX_W-1:0]     i_green = '0;
    logic [r2n_pkg::PIX_W-1:0]     i_blue = '0;
    logic                          o_valid;
    logic                          i_ready = 1'b0;
    logic                          o_plane;
    logic [r2n_pkg::OFF_W-1:0]     o_offset;
    logic [r2n_pkg::PIX_W-1:0]     o_first_value;
    logic [r2n_pkg::PIX_W-1:0]     o_second_value;
    logic                          o_last_of_run;
    logic                          o_frame_end;
    logic                          i_cfg_we = 1'b0;
    logic [r2n_pkg::CFG_IDX_W-1:0] i_cfg_index = r2n_pkg::REG_FRAME_WIDTH;
    logic [r2n_pkg::CFG_W-1:0]     i_cfg_data = '0;

    // Predicted copy of the block's registers and position. Reset values match the block.
    logic [r2n_pkg::CFG_W-1:0] width_reg  = r2n_pkg::CFG_W'(r2n_pkg::RESET_WIDTH);
    logic [r2n_pkg::CFG_W-1:0] height_reg = r2n_pkg::CFG_W'(r2n_pkg::RESET_HEIGHT);
    int                        px_col = 0;
    int                        px_row = 0;
    logic [r2n_pkg::PIX_W-1:0] left_u = '0;
    logic [r2n_pkg::PIX_W-1:0] left_v = '0;
    // Even-row pair sums of U and V, one entry per two columns.
    logic [r2n_pkg::PAIR_W-1:0] upper_u_sum [r2n_pkg::LINE_DEPTH];
    logic [r2n_pkg::PAIR_W-1:0] upper_v_sum [r2n_pkg::LINE_DEPTH];

    // Plane writes still owed by the block, oldest first.
    r2n_pkg::t_result plane_writes [$];
    int               bad_writes = 0;

    // Idle rates in percent, and the long receiver hold-off requests.
    int send_idle_pct = 7;
    int recv_idle_pct = 53;
    int hold_requests = 0;
    int holds_served  = 0;
    int hold_left     = 0;
    int cycle_count   = 0;
    bit cfg_we_high   = 1'b0;

    // The opening table. After reset the frame is 640 by 480, so the first five pixels are
    // luma-only writes at offsets 0..4 whose bytes can be read straight off the formula:
    // black 16, white 235, pure red 82, pure green 144, pure blue 41.
    t_stim_row opening_rows [24] = '{
        '{ROW_PIXEL, 8'd0,   8'd0,   8'd0,   1'b1, 8'd16,  24'd0, r2n_pkg::REG_FRAME_WIDTH, 13'd0},
        '{ROW_PIXEL, 8'd255, 8'd255, 8'd255, 1'b1, 8'd235, 24'd1, r2n_pkg::REG_FRAME_WIDTH, 13'd0},
        '{ROW_PIXEL, 8'd255, 8'd0,   8'd0,   1'b1, 8'd82,  24'd2, r2n_pkg::REG_FRAME_WIDTH, 13'd0},
        '{ROW_PIXEL, 8'd0,   8'd255, 8'd0,   1'b1, 8'd144, 24'd3, r2n_pkg::REG_FRAME_WIDTH, 13'd0},
        '{ROW_PIXEL, 8'd0,   8'd0,   8'd255, 1'b1, 8'd41,  24'd4, r2n_pkg::REG_FRAME_WIDTH, 13'd0},
        // Mid-frame writes below the minimum: both sizes become 2 and the frame restarts.
        '{ROW_WRITE, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 24'd0, r2n_pkg::REG_FRAME_WIDTH,  13'd1},
        '{ROW_WRITE, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 24'd0, r2n_pkg::REG_FRAME_HEIGHT, 13'd0},
        // One whole 2x2 frame: chroma pair and frame end on the fourth pixel.
        '{ROW_PIXEL, 8'd255, 8'd255, 8'd255, 1'b0, 8'd0, 24'd0, r2n_pkg::REG_FRAME_WIDTH, 13'd0},
        '{ROW_PIXEL, 8'd0,   8'd0,   8'd0,   1'b0, 8'd0, 24'd0, r2n_pkg::REG_FRAME_WIDTH, 13'd0},
        '{ROW_PIXEL, 8'd255, 8'd0,   8'd0,   1'b0, 8'd0, 24'd0, r2n_pkg::REG_FRAME_WIDTH, 13'd0},
        '{ROW_PIXEL, 8'd0,   8'd0,   8'd255, 1'b0, 8'd0, 24'd0, r2n_pkg::REG_FRAME_WIDTH, 13'd0},
        // The frame wraps to row 0 without any write.
        '{ROW_PIXEL, 8'd255, 8'd0,   8'd255, 1'b0, 8'd0, 24'd0, r2n_pkg::REG_FRAME_WIDTH, 13'd0},
        '{ROW_PIXEL, 8'd0,   8'd255, 8'd255, 1'b0, 8'd0, 24'd0, r2n_pkg::REG_FRAME_WIDTH, 13'd0},
        '{ROW_PIXEL, 8'd255, 8'd255, 8'd0,   1'b0, 8'd0, 24'd0, r2n_pkg::REG_FRAME_WIDTH, 13'd0},
        '{ROW_PIXEL, 8'd128, 8'd128, 8'd128, 1'b0, 8'd0, 24'd0, r2n_pkg::REG_FRAME_WIDTH, 13'd0},
        // Width above the maximum is capped at 4096; an odd height loses its low bit.
        '{ROW_WRITE, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 24'd0, r2n_pkg::REG_FRAME_WIDTH,  13'd8191},
        '{ROW_WRITE, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 24'd0, r2n_pkg::REG_FRAME_HEIGHT, 13'd3},
        '{ROW_PIXEL, 8'd0,   8'd0,   8'd0,   1'b0, 8'd0, 24'd0, r2n_pkg::REG_FRAME_WIDTH, 13'd0},
        '{ROW_PIXEL, 8'd255, 8'd255, 8'd255, 1'b0, 8'd0, 24'd0, r2n_pkg::REG_FRAME_WIDTH, 13'd0},
        '{ROW_WRITE, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 24'd0, r2n_pkg::REG_FRAME_WIDTH,  13'd6},
        '{ROW_WRITE, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 24'd0, r2n_pkg::REG_FRAME_HEIGHT, 13'd4},
        // A partial row; the random part that follows usually restarts the frame mid-row.
        '{ROW_PIXEL, 8'd17,  8'd200, 8'd3,   1'b0, 8'd0, 24'd0, r2n_pkg::REG_FRAME_WIDTH, 13'd0},
        '{ROW_PIXEL, 8'd254, 8'd1,   8'd127, 1'b0, 8'd0, 24'd0, r2n_pkg::REG_FRAME_WIDTH, 13'd0},
        '{ROW_PIXEL, 8'd85,  8'd170, 8'd85,  1'b0, 8'd0, 24'd0, r2n_pkg::REG_FRAME_WIDTH, 13'd0}
    };

    rgb_to_nv12_converter uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_red          (i_red),
        .i_green        (i_green),
        .i_blue         (i_blue),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_plane        (o_plane),
        .o_offset       (o_offset),
        .o_first_value  (o_first_value),
        .o_second_value (o_second_value),
        .o_last_of_run  (o_last_of_run),
        .o_frame_end    (o_frame_end),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // 100 MHz clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Size actually used by the block: low bit dropped, then held between 2 and the limit.
    function automatic int frame_extent(input logic [r2n_pkg::CFG_W-1:0] raw, input int limit);
        int s;
        s = int'(raw) & ~1;
        if (s < 2) begin
            s = 2;
        end
        if (s > limit) begin
            s = limit & ~1;
        end
        return s;
    endfunction

    // Works out the plane writes caused by one accepted pixel and queues them, then moves
    // the raster position on. Chroma comes out at the odd column of every odd row as the
    // floor of the mean of the 2x2 block's U and V; the even row's pair sums wait in
    // upper_u_sum / upper_v_sum and the even column's U and V in left_u / left_v.
    function automatic void convert_pixel(input logic [r2n_pkg::PIX_W-1:0] r, g, b,
                                          input bit typed,
                                          input logic [r2n_pkg::PIX_W-1:0] typed_luma,
                                          input logic [r2n_pkg::OFF_W-1:0] typed_offset);
        int                          w, h, idx, ri, gi, bi;
        logic [r2n_pkg::PIX_W-1:0]   y, u, v;
        logic [r2n_pkg::PIX_W+1:0]   su, sv;
        logic                        last_px;
        r2n_pkg::t_result            luma_wr, chroma_wr;
        w = frame_extent(width_reg, r2n_pkg::MAX_WIDTH);
        h = frame_extent(height_reg, r2n_pkg::MAX_HEIGHT);
        ri = r;
        gi = g;
        bi = b;
        // The chroma sums carry a bias of 128 * 256 so that the shift never sees a
        // negative number; the shift then acts as a floor.
        y = r2n_pkg::PIX_W'(((66 * ri + 129 * gi + 25 * bi + 128) >>> 8) + 16);
        u = r2n_pkg::PIX_W'((-38 * ri - 74 * gi + 112 * bi + 128 + 32768) >>> 8);
        v = r2n_pkg::PIX_W'((112 * ri - 94 * gi - 18 * bi + 128 + 32768) >>> 8);
        last_px = (px_col + 1 >= w) && (px_row + 1 >= h);
        idx = px_col >> 1;
        if ((px_col & 1) == 0) begin
            left_u = u;
            left_v = v;
        end

        luma_wr.plane        = r2n_pkg::PLANE_LUMA;
        luma_wr.offset       = typed ? typed_offset : r2n_pkg::OFF_W'(px_row * w + px_col);
        luma_wr.first_value  = typed ? typed_luma : y;
        luma_wr.second_value = '0;
        luma_wr.last_of_run  = 1'b1;
        luma_wr.frame_end    = last_px;

        if ((px_col & 1) == 1 && (px_row & 1) == 1) begin
            su = upper_u_sum[idx] + left_u + u;
            sv = upper_v_sum[idx] + left_v + v;
            luma_wr.last_of_run    = 1'b0;
            luma_wr.frame_end      = 1'b0;
            chroma_wr.plane        = r2n_pkg::PLANE_CHROMA;
            chroma_wr.offset       = r2n_pkg::OFF_W'((px_row >> 1) * w + (px_col & ~1));
            chroma_wr.first_value  = su[r2n_pkg::PIX_W+1:2];
            chroma_wr.second_value = sv[r2n_pkg::PIX_W+1:2];
            chroma_wr.last_of_run  = 1'b1;
            chroma_wr.frame_end    = last_px;
            plane_writes.push_back(luma_wr);
            plane_writes.push_back(chroma_wr);
        end else begin
            if ((px_col & 1) == 1) begin
                upper_u_sum[idx] = left_u + u;
                upper_v_sum[idx] = left_v + v;
            end
            plane_writes.push_back(luma_wr);
        end

        if (px_col + 1 >= w) begin
            px_col = 0;
            px_row = (px_row + 1 >= h) ? 0 : px_row + 1;
        end else begin
            px_col = px_col + 1;
        end
    endfunction

    // Offers one pixel, possibly after a few idle cycles, and holds it until the block
    // takes it. The prediction is made at the edge that accepts the item.
    task automatic push_pixel(input logic [r2n_pkg::PIX_W-1:0] r, g, b, input bit typed,
                              input logic [r2n_pkg::PIX_W-1:0] typed_luma,
                              input logic [r2n_pkg::OFF_W-1:0] typed_offset);
        if (cfg_we_high) begin
            i_cfg_we <= 1'b0;
            cfg_we_high = 1'b0;
        end
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_red   <= r;
        i_green <= g;
        i_blue  <= b;
        @(posedge i_clk);
        while (!o_ready) begin
            @(posedge i_clk);
        end
        convert_pixel(r, g, b, typed, typed_luma, typed_offset);
    endtask

    // Writes one size register once the block has delivered everything it owes, so that
    // no pixel is in flight. Every pixel yields at least one write, so an empty queue means
    // the block is idle. The write enable is left high so that back-to-back writes need
    // only one assignment per edge; the next pixel or the end of the run lowers it.
    task automatic write_frame_reg(input logic [r2n_pkg::CFG_IDX_W-1:0] index,
                                   input logic [r2n_pkg::CFG_W-1:0] data);
        i_valid <= 1'b0;
        while (plane_writes.size() != 0) begin
            @(posedge i_clk);
        end
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        cfg_we_high = 1'b1;
        @(posedge i_clk);
        if (index == r2n_pkg::REG_FRAME_WIDTH) begin
            width_reg = data;
        end else begin
            height_reg = data;
        end
        // Any size write restarts the frame.
        px_col = 0;
        px_row = 0;
    endtask

    // Color level: mostly uniform, with the two extremes favored.
    function automatic logic [r2n_pkg::PIX_W-1:0] pick_level();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return r2n_pkg::PIX_W'($urandom_range(255));
        endcase
    endfunction

    // Raw size register value: mostly small, sometimes below the minimum, above the
    // maximum or anywhere in range. Odd values are left in on purpose.
    function automatic logic [r2n_pkg::CFG_W-1:0] pick_size_raw(input int small_hi);
        case ($urandom_range(19))
            0: return r2n_pkg::CFG_W'($urandom_range(1));
            1: return r2n_pkg::CFG_W'($urandom_range(r2n_pkg::MAX_WIDTH + 1, 8191));
            2: return r2n_pkg::CFG_W'($urandom_range(2, r2n_pkg::MAX_WIDTH));
            default: return r2n_pkg::CFG_W'($urandom_range(2, small_hi));
        endcase
    endfunction

    // One stretch of random traffic at the given idle rates. Each segment usually picks new
    // sizes, then sends whole frames (often with a partial one after them, so the next
    // write lands mid-frame) when the frame is small, or up to 300 pixels when it is large.
    // A long receiver hold-off is requested at the start of every stretch.
    task automatic run_stretch(input int send_pct, input int recv_pct, input int quota);
        int                        sent, fw, fh, area, n;
        logic [r2n_pkg::CFG_W-1:0] raw_w, raw_h;
        bit                        do_w, do_h, first;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        sent = 0;
        first = 1'b1;
        while (sent < quota) begin
            if ($urandom_range(99) < 80) begin
                do_w = $urandom_range(99) < 70;
                do_h = ($urandom_range(99) < 70) || !do_w;
                raw_w = pick_size_raw(24);
                raw_h = pick_size_raw(10);
                if ($urandom_range(1) == 1) begin
                    if (do_w) write_frame_reg(r2n_pkg::REG_FRAME_WIDTH, raw_w);
                    if (do_h) write_frame_reg(r2n_pkg::REG_FRAME_HEIGHT, raw_h);
                end else begin
                    if (do_h) write_frame_reg(r2n_pkg::REG_FRAME_HEIGHT, raw_h);
                    if (do_w) write_frame_reg(r2n_pkg::REG_FRAME_WIDTH, raw_w);
                end
            end
            fw = frame_extent(width_reg, r2n_pkg::MAX_WIDTH);
            fh = frame_extent(height_reg, r2n_pkg::MAX_HEIGHT);
            area = fw * fh;
            if (area <= 128) begin
                n = area * $urandom_range(1, 3);
                if ($urandom_range(99) < 30) begin
                    n = n + $urandom_range(0, area - 1);
                end
            end else begin
                n = $urandom_range(1, 300);
            end
            if (first) begin
                hold_requests++;
                first = 1'b0;
            end
            repeat (n) begin
                push_pixel(pick_level(), pick_level(), pick_level(), 1'b0, '0, '0);
            end
            sent = sent + n;
        end
    endtask

    // Receiver: random stalls at the current rate, or a long hold-off when one has been
    // requested, so that the result queue fills and the block stops taking pixels.
    always @(posedge i_clk) begin
        if (hold_requests != holds_served) begin
            holds_served = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Result checker: every accepted plane write must match the oldest one owed.
    always @(posedge i_clk) begin : check_writes
        r2n_pkg::t_result got, want;
        if (i_rst_n && o_valid && i_ready) begin
            got = {o_plane, o_offset, o_first_value, o_second_value, o_last_of_run,
                   o_frame_end};
            if (plane_writes.size() == 0) begin
                if (bad_writes < 10) begin
                    $display("unexpected write: plane %0d offset %0d values %0d/%0d",
                             got.plane, got.offset, got.first_value, got.second_value);
                end
                bad_writes++;
            end else begin
                want = plane_writes.pop_front();
                if (got !== want) begin
                    if (bad_writes < 10) begin
                        $display("mismatch at %0t: expected plane %0d off %0d vals %0d/%0d",
                                 $realtime, want.plane, want.offset, want.first_value,
                                 want.second_value);
                        $display("  last %0d end %0d; got plane %0d off %0d vals %0d/%0d",
                                 want.last_of_run, want.frame_end, got.plane, got.offset,
                                 got.first_value, got.second_value);
                        $display("  last %0d end %0d", got.last_of_run, got.frame_end);
                    end
                    bad_writes++;
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // Main sequence: reset, the opening table, three random stretches with different idle
    // patterns, then the start of the widest and of the tallest frames, and the verdict.
    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (opening_rows[k]) begin
            if (opening_rows[k].kind == ROW_WRITE) begin
                write_frame_reg(opening_rows[k].reg_index, opening_rows[k].reg_data);
            end else begin
                push_pixel(opening_rows[k].red, opening_rows[k].green, opening_rows[k].blue,
                           opening_rows[k].typed, opening_rows[k].typed_luma,
                           opening_rows[k].typed_offset);
            end
        end

        run_stretch(7, 53, 500);
        run_stretch(53, 7, 500);
        run_stretch(0, 0, 450);

        // Widest frame, width at the limit, two rows; only the start of its first row, under
        // a long receiver hold-off.
        write_frame_reg(r2n_pkg::REG_FRAME_WIDTH, r2n_pkg::CFG_W'(r2n_pkg::MAX_WIDTH));
        write_frame_reg(r2n_pkg::REG_FRAME_HEIGHT, r2n_pkg::CFG_W'(2));
        hold_requests++;
        repeat (200) begin
            push_pixel(pick_level(), pick_level(), pick_level(), 1'b0, '0, '0);
        end

        // Tallest frame, height capped from above the maximum; only its first rows.
        write_frame_reg(r2n_pkg::REG_FRAME_HEIGHT, r2n_pkg::CFG_W'(8191));
        write_frame_reg(r2n_pkg::REG_FRAME_WIDTH, r2n_pkg::CFG_W'(2));
        repeat (100) begin
            push_pixel(pick_level(), pick_level(), pick_level(), 1'b0, '0, '0);
        end

        i_valid <= 1'b0;
        if (cfg_we_high) begin
            i_cfg_we <= 1'b0;
        end
        while (plane_writes.size() != 0) begin
            @(posedge i_clk);
        end
        // Give any surplus write time to show up.
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (bad_writes == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
